// File: rtl/gtsp_pkg.sv
package gtsp_pkg;

	// item kinds carried on s_tuser
	typedef enum logic [0:0] {
		ACT_START = 1'b0,
		ACT_TICK  = 1'b1
	} action_t;

	localparam int unsigned TARGET_W  = 13;
	localparam int unsigned SPEED_W   = 7;
	localparam int unsigned HEADING_W = 16;
	localparam int unsigned MAG_W     = 12;
	localparam int unsigned SLOW_W    = 8;
	localparam int unsigned DRIVE_W   = 8;

	localparam int unsigned SDATA_W   = 40;
	localparam int unsigned MDATA_W   = 24;

	localparam logic [SPEED_W-1:0] TURN_SPEED_RST = 7'd127;

	// slowdown kicks in once this many degrees or fewer remain
	localparam logic [MAG_W-1:0] NEAR_LIMIT = 12'd38;
	localparam logic [SLOW_W-1:0] SLOW_MAX  = 8'd255;

	// x/10 for x <= 4096: (x * 3277) >> 15
	localparam logic [11:0] TENTH_MUL = 12'd3277;
	localparam int unsigned TENTH_SH  = 15;

	// x/3 for x <= 38: (x * 43) >> 7
	localparam logic [5:0] THIRD_MUL = 6'd43;
	localparam int unsigned THIRD_SH = 7;

endpackage

// File: rtl/gyro_turn_speed_profiler_top.sv
// channel  dir  signals                         word
// s        in   s_tvalid s_tready s_tdata s_tuser  start or tick item
// m        out  m_tvalid m_tready m_tdata        drive command
// cfg      in   cfg_valid cfg_ready cfg_data     turn_speed write
//
// One word per cycle while m_tready is high; path: input stage, result register.
// Target reduction is done before the input stage, the turn update after it.
// Reset clears the turn (idle), the slowdown and sets turn_speed to 127.
// A stalled m side holds the result; s_tready drops only when both stages are full.
// cfg_ready is always high.
module gyro_turn_speed_profiler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [12:0] target_degrees, [19:13] min_speed, [35:20] heading, [39:36] zero
	input  logic [39:0] s_tdata,
	// [0] action
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] left_drive, [15:8] right_drive, [16] done_res, [23:17] zero
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	// input stage
	logic                                  v_s1;
	gtsp_pkg::action_t                     action_s1;
	logic [gtsp_pkg::MAG_W-1:0]            mag_s1;
	logic                                  sign_s1;
	logic [gtsp_pkg::SPEED_W-1:0]          floor_s1;
	logic signed [gtsp_pkg::HEADING_W-1:0] heading_s1;

	// turn state
	logic                                  active_q;
	logic signed [gtsp_pkg::HEADING_W-1:0] start_heading_q;
	logic [gtsp_pkg::MAG_W-1:0]            target_mag_q;
	logic                                  turn_sign_q;
	logic [gtsp_pkg::SLOW_W-1:0]           slowdown_q;
	logic [gtsp_pkg::SPEED_W-1:0]          floor_speed_q;
	logic [gtsp_pkg::SPEED_W-1:0]          turn_speed_q;

	// result register
	logic                                  out_valid_q;
	logic [gtsp_pkg::DRIVE_W-1:0]          drive_q;
	logic                                  done_q;

	logic advance;
	logic take;

	// front-end target reduction
	logic signed [gtsp_pkg::TARGET_W-1:0]  in_target;
	logic [gtsp_pkg::TARGET_W-1:0]         in_abs;
	logic [24:0]                           tenth_prod;
	logic [9:0]                            tenth;
	logic [gtsp_pkg::TARGET_W-1:0]         in_mag;

	// tick datapath
	logic signed [gtsp_pkg::HEADING_W:0]   diff;
	logic [gtsp_pkg::HEADING_W:0]          turned;
	logic                                  in_range;
	logic [gtsp_pkg::MAG_W-1:0]            remaining;
	logic [11:0]                           third_prod;
	logic [4:0]                            third;
	logic [gtsp_pkg::SLOW_W:0]             slow_sum;
	logic [gtsp_pkg::SLOW_W-1:0]           slow_next;
	logic signed [gtsp_pkg::SLOW_W:0]      speed_raw;
	logic [gtsp_pkg::SPEED_W-1:0]          speed;
	logic [gtsp_pkg::DRIVE_W-1:0]          drive_next;

	assign advance   = v_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !v_s1 || advance;
	assign take      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		in_target  = s_tdata[12:0];
		in_abs     = in_target[gtsp_pkg::TARGET_W-1] ? (~in_target + 13'd1) : in_target;
		tenth_prod = {12'd0, in_abs} * {13'd0, gtsp_pkg::TENTH_MUL};
		tenth      = tenth_prod[24:gtsp_pkg::TENTH_SH];
		in_mag     = in_abs - {3'd0, tenth};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1  <= gtsp_pkg::action_t'(s_tuser[0]);
			mag_s1     <= in_mag[gtsp_pkg::MAG_W-1:0];
			sign_s1    <= !in_target[gtsp_pkg::TARGET_W-1] && (in_target != '0);
			floor_s1   <= s_tdata[19:13];
			heading_s1 <= s_tdata[35:20];
		end
	end

	always_comb begin
		diff       = {start_heading_q[gtsp_pkg::HEADING_W-1], start_heading_q}
		           - {heading_s1[gtsp_pkg::HEADING_W-1], heading_s1};
		turned     = diff[gtsp_pkg::HEADING_W] ? (~diff + 17'd1) : diff;
		in_range   = turned <= {5'd0, target_mag_q};
		remaining  = target_mag_q - turned[gtsp_pkg::MAG_W-1:0];
		third_prod = {6'd0, remaining[5:0]} * {6'd0, gtsp_pkg::THIRD_MUL};
		third      = third_prod[11:gtsp_pkg::THIRD_SH];
		slow_sum   = {1'b0, slowdown_q} + {4'd0, third};
		if (remaining > gtsp_pkg::NEAR_LIMIT) begin
			slow_next = slowdown_q;
		end else if (slow_sum[gtsp_pkg::SLOW_W]) begin
			slow_next = gtsp_pkg::SLOW_MAX;
		end else begin
			slow_next = slow_sum[gtsp_pkg::SLOW_W-1:0];
		end
		speed_raw = $signed({2'b00, turn_speed_q}) - $signed({1'b0, slow_next});
		if (speed_raw < $signed({2'b00, floor_speed_q})) begin
			speed = floor_speed_q;
		end else begin
			speed = speed_raw[gtsp_pkg::SPEED_W-1:0];
		end
		drive_next = turn_sign_q ? {1'b0, speed} : (~{1'b0, speed} + 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_speed_q <= gtsp_pkg::TURN_SPEED_RST;
		end else if (cfg_valid) begin
			turn_speed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			start_heading_q <= '0;
			target_mag_q    <= '0;
			turn_sign_q     <= 1'b0;
			slowdown_q      <= '0;
			floor_speed_q   <= '0;
		end else if (advance) begin
			if (action_s1 == gtsp_pkg::ACT_START) begin
				active_q        <= 1'b1;
				start_heading_q <= heading_s1;
				target_mag_q    <= mag_s1;
				turn_sign_q     <= sign_s1;
				slowdown_q      <= '0;
				floor_speed_q   <= floor_s1;
			end else if (active_q) begin
				if (in_range) begin
					slowdown_q <= slow_next;
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (action_s1 == gtsp_pkg::ACT_START) begin
				drive_q <= '0;
				done_q  <= 1'b0;
			end else if (active_q && in_range) begin
				drive_q <= drive_next;
				done_q  <= 1'b0;
			end else begin
				drive_q <= '0;
				done_q  <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, done_q, drive_q, drive_q};

	// both motors always get the same command
	a_same_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] == m_tdata[15:8])
		else $error("left and right drive differ");

	// a finished or idle turn stops the motors
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[7:0] == 8'd0)
		else $error("nonzero drive with done");

	// slowdown only grows during a turn
	a_slow_mono: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == gtsp_pkg::ACT_TICK |=> slowdown_q >= $past(slowdown_q))
		else $error("slowdown decreased on a tick");

	// a tick never starts a turn
	a_tick_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == gtsp_pkg::ACT_TICK && !active_q |=> !active_q)
		else $error("tick activated an idle turn");

endmodule

// File: dv/gyro_turn_speed_profiler_top_tb.sv
module gyro_turn_speed_profiler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TENTH_DIV      = 10;
	localparam int THIRD_DIV      = 3;
	localparam int WATCHDOG_LIMIT = 300;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic [gtsp_pkg::DRIVE_W-1:0] left_drive;
		logic [gtsp_pkg::DRIVE_W-1:0] right_drive;
		logic                         done_res;
	} drive_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [gtsp_pkg::SDATA_W-1:0] s_tdata = '0;
	logic [0:0]                   s_tuser = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [gtsp_pkg::MDATA_W-1:0] m_tdata;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [gtsp_pkg::SPEED_W-1:0] cfg_data = '0;

	// shadow copy of the turn state
	logic [gtsp_pkg::SPEED_W-1:0]          base_speed = gtsp_pkg::TURN_SPEED_RST;
	logic signed [gtsp_pkg::HEADING_W-1:0] turn_origin = '0;
	logic [gtsp_pkg::MAG_W-1:0]            turn_goal = '0;
	bit                                    turn_right = 1'b0;
	logic [gtsp_pkg::SLOW_W-1:0]           slow_acc = '0;
	logic [gtsp_pkg::SPEED_W-1:0]          speed_floor = '0;
	bit                                    turning = 1'b0;

	drive_t pending_drives[$];
	drive_t want;
	int     mismatch_count = 0;
	int     items_sent = 0;
	int     quiet_cycles = 0;
	int     stall_cycles = 0;
	bit     gaps_on = 1'b1;

	gyro_turn_speed_profiler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic drive_t predict_drive(gtsp_pkg::action_t act,
			logic signed [gtsp_pkg::TARGET_W-1:0] tgt, logic [gtsp_pkg::SPEED_W-1:0] mn,
			logic signed [gtsp_pkg::HEADING_W-1:0] hd);
		int     t;
		int     r;
		int     diff;
		int     turned;
		int     remaining;
		int     sum;
		int     speed;
		drive_t d;
		d = '0;
		if (act == gtsp_pkg::ACT_START) begin
			t = tgt;
			r = t - t / TENTH_DIV;
			turn_right = (t > 0);
			turn_goal = 12'((r < 0) ? -r : r);
			turn_origin = hd;
			slow_acc = '0;
			speed_floor = mn;
			turning = 1'b1;
		end else if (!turning) begin
			d.done_res = 1'b1;
		end else begin
			diff = int'(turn_origin) - int'(hd);
			turned = (diff < 0) ? -diff : diff;
			if (turned <= int'(turn_goal)) begin
				remaining = int'(turn_goal) - turned;
				if (remaining <= int'(gtsp_pkg::NEAR_LIMIT)) begin
					sum = int'(slow_acc) + remaining / THIRD_DIV;
					slow_acc = (sum > int'(gtsp_pkg::SLOW_MAX)) ? gtsp_pkg::SLOW_MAX : 8'(sum);
				end
				speed = int'(base_speed) - int'(slow_acc);
				if (speed < int'(speed_floor))
					speed = int'(speed_floor);
				d.left_drive = 8'(turn_right ? speed : -speed);
				d.right_drive = d.left_drive;
			end else begin
				turning = 1'b0;
				d.done_res = 1'b1;
			end
		end
		return d;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// leaves s_tvalid high on return so back-to-back words need no extra step
	task automatic send_item(input gtsp_pkg::action_t act,
			input logic signed [gtsp_pkg::TARGET_W-1:0] tgt,
			input logic [gtsp_pkg::SPEED_W-1:0] mn,
			input logic signed [gtsp_pkg::HEADING_W-1:0] hd);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, hd, mn, tgt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_drives.push_back(predict_drive(act, tgt, mn, hd));
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_drives.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// only called with the block drained
	task automatic write_turn_speed(input logic [gtsp_pkg::SPEED_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		base_speed = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_turn_sequence();
		int                                    tgt;
		int                                    goal;
		int                                    offset;
		int                                    dir;
		int                                    n;
		logic signed [gtsp_pkg::HEADING_W-1:0] origin;
		case ($urandom_range(0, 9))
			0: send_item(gtsp_pkg::ACT_START, 13'($urandom_range(0, 7200) - 3600),
				7'($urandom), 16'($urandom));
			1: send_item(gtsp_pkg::ACT_TICK, 13'($urandom_range(0, 7200) - 3600),
				7'($urandom), 16'($urandom));
			default: begin
				tgt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3600) : $urandom_range(0, 160);
				if ($urandom_range(0, 1))
					tgt = -tgt;
				goal = tgt - tgt / TENTH_DIV;
				if (goal < 0)
					goal = -goal;
				origin = 16'($urandom);
				dir = $urandom_range(0, 1) ? 1 : -1;
				offset = 0;
				send_item(gtsp_pkg::ACT_START, 13'(tgt), 7'($urandom), origin);
				// walk the heading toward the goal; holds build up slowdown near the end
				for (n = 0; n < 80 && offset <= goal; n++) begin
					case ($urandom_range(0, 11))
						0, 1, 2: ;
						3, 4, 5, 6: offset += $urandom_range(1, 4);
						7: offset += $urandom_range(1, goal / 4 + 1);
						8: if (offset > 0) offset--;
						9: if ($urandom_range(0, 7) == 0) offset = goal + $urandom_range(1, 40000);
						10: if ($urandom_range(0, 15) == 0) dir = -dir;
						default: offset++;
					endcase
					send_item(gtsp_pkg::ACT_TICK, 13'($urandom_range(0, 7200) - 3600),
						7'($urandom), 16'(int'(origin) + dir * offset));
				end
			end
		endcase
	endtask

	task automatic test_turn_runs(input int n_items, input bit with_gaps);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			gaps_on = with_gaps && ($urandom_range(0, 4) != 0);
			run_turn_sequence();
		end
	endtask

	task automatic test_directed_cases();
		gaps_on = 1'b0;
		// ticks with no turn in progress, fields ignored
		send_item(gtsp_pkg::ACT_TICK, 13'sd3600, 7'd127, 16'sh8000);
		send_item(gtsp_pkg::ACT_TICK, -13'sd3600, 7'd0, 16'sh7fff);
		// zero target turns left while on the start heading
		send_item(gtsp_pkg::ACT_START, 13'sd0, 7'd0, 16'sd100);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd100);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd101);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd100);
		// largest right turn, heading jump across the whole range
		send_item(gtsp_pkg::ACT_START, 13'sd3600, 7'd127, 16'sh8000);
		send_item(gtsp_pkg::ACT_TICK, -13'sd3600, 7'd0, 16'sh8000);
		send_item(gtsp_pkg::ACT_TICK, -13'sd3600, 7'd0, 16'sh7fff);
		// largest left turn, slowdown near the end, one degree past
		send_item(gtsp_pkg::ACT_START, -13'sd3600, 7'd0, 16'sh7fff);
		send_item(gtsp_pkg::ACT_TICK, 13'sd1, 7'd1, 16'sd29557);
		send_item(gtsp_pkg::ACT_TICK, 13'sd1, 7'd1, 16'sd29527);
		send_item(gtsp_pkg::ACT_TICK, 13'sd1, 7'd1, 16'sd29526);
		// tenth truncated toward zero, then a restart in the middle of the turn
		send_item(gtsp_pkg::ACT_START, -13'sd15, 7'd5, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, -16'sd14);
		send_item(gtsp_pkg::ACT_START, 13'sd15, 7'd120, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd15);
		send_item(gtsp_pkg::ACT_START, 13'sd9, 7'd0, 16'sd5);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd0);
		send_item(gtsp_pkg::ACT_TICK, 13'sd0, 7'd0, 16'sd15);
	endtask

	task automatic test_speed_settings();
		logic [gtsp_pkg::SPEED_W-1:0] speeds[4];
		speeds = '{7'd0, 7'd1, 7'($urandom), 7'($urandom_range(40, 90))};
		foreach (speeds[i]) begin
			wait_drained();
			write_turn_speed(speeds[i]);
			test_turn_runs(110, 1'b1);
		end
	endtask

	task automatic test_pause_for_results();
		test_turn_runs(50, 1'b1);
		wait_drained();
		test_turn_runs(50, 1'b1);
	endtask

	task automatic test_no_gaps();
		wait_drained();
		write_turn_speed(gtsp_pkg::TURN_SPEED_RST);
		test_turn_runs(170, 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_cycles != 0) begin
			stall_cycles <= stall_cycles - 1;
		end else if (gaps_on && $urandom_range(0, 6) == 0) begin
			m_tready <= 1'b0;
			stall_cycles <= $urandom_range(0, 9);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				report_mismatch($sformatf("drive word %h with nothing expected", m_tdata));
			end else begin
				want = pending_drives.pop_front();
				if (m_tdata[7:0] !== want.left_drive)
					report_mismatch($sformatf("left_drive got %0d want %0d",
						$signed(m_tdata[7:0]), $signed(want.left_drive)));
				if (m_tdata[15:8] !== want.right_drive)
					report_mismatch($sformatf("right_drive got %0d want %0d",
						$signed(m_tdata[15:8]), $signed(want.right_drive)));
				if (m_tdata[16] !== want.done_res)
					report_mismatch($sformatf("done_res got %b want %b",
						m_tdata[16], want.done_res));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_turn_runs(200, 1'b1);
		test_speed_settings();
		test_pause_for_results();
		test_no_gaps();
		wait_drained();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
